// ===== rtl/core/ihl_pkg.sv =====
// Package for the Intel HEX loader: request and result types, the command and
// status structs between controller and datapath, and the fixed codes.
// No dependencies.
package ihl_pkg;

	// One input request and one result item.
	typedef struct packed {
		logic        req_type;
		logic [7:0]  char_code;
		logic [15:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  read_data;
		logic        read_written;
		logic [16:0] image_size;
		logic [16:0] useful_count;
		logic [15:0] first_address;
		logic [15:0] line_count;
	} out_item_t;

	// Commands from the controller, at most one high per cycle.
	typedef struct packed {
		logic clr;
		logic accept;
		logic exec;
		logic cm_init;
		logic chk_rd;
		logic chk_eval;
		logic wr_rd;
		logic wr_do;
		logic rd_issue;
		logic rd_cap;
		logic resp;
	} cmd_t;

	// Status back from the datapath.
	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic need_commit;
		logic range_bad;
		logic len_zero;
		logic strict;
		logic overlap_hit;
		logic cnt_last;
		logic out_free;
	} sts_t;

	// Parser phases.
	localparam logic [2:0] PH_LINE = 3'd0;
	localparam logic [2:0] PH_HI   = 3'd1;
	localparam logic [2:0] PH_LO   = 3'd2;
	localparam logic [2:0] PH_TAIL = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;
	localparam logic [2:0] PH_ERR  = 3'd5;

	// Load status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_END      = 3'd1;
	localparam logic [2:0] ST_BADSTART = 3'd2;
	localparam logic [2:0] ST_BADHEX   = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;
	localparam logic [2:0] ST_OVERLAP  = 3'd5;
	localparam logic [2:0] ST_RANGE    = 3'd6;
	localparam logic [2:0] ST_SHORT    = 3'd7;

	// Characters and record kinds.
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] KIND_DATA = 8'h00;
	localparam logic [7:0] KIND_EOF  = 8'h01;
	localparam logic [7:0] KIND_SEG  = 8'h02;
	localparam logic [7:0] KIND_LIN  = 8'h04;
	localparam int SEG_SHIFT = 4;
	localparam int LIN_SHIFT = 16;

	// Configuration register indexes.
	localparam logic [7:0] CFG_STRICT = 8'd0;
	localparam logic [7:0] CFG_FILL   = 8'd1;

endpackage

// ===== rtl/core/ihl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ihl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ihl_datapath.sv =====
// Datapath of the Intel HEX loader: parser registers, record buffer, image
// store, written map, counters and the result register.
// Depends on ihl_pkg and ihl_ram.
module ihl_datapath #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ihl_pkg::cmd_t     cmd,
	output ihl_pkg::sts_t     sts,
	input  ihl_pkg::in_item_t in_data,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              out_stall,
	output logic              out_valid,
	output ihl_pkg::out_item_t out_data
);
	import ihl_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;

	// Hex digit decode: bit 4 flags a valid digit.
	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	logic        strict_q;
	logic [7:0]  fill_q;
	in_item_t    req_q;
	logic [2:0]  phase_q;
	logic [3:0]  hi_q;
	logic [8:0]  idx_q;
	logic [7:0]  len_q;
	logic [15:0] offset_q;
	logic [7:0]  kind_q;
	logic [7:0]  sum_q;
	logic [31:0] base_q;
	logic [7:0]  b0_q, b1_q;
	logic [AW:0]   top_q;
	logic [AW-1:0] low_q;
	logic          any_q;
	logic [AW:0]   dist_q;
	logic [15:0]   seen_q;
	logic [2:0]    status_q;
	logic [AW-1:0] clr_cnt_q;
	logic          clr_done_q;
	logic [AW-1:0] pos_q, start_q;
	logic [AW:0]   end_q;
	logic [7:0]    cnt_q;
	logic [7:0]    rdata_q;
	logic          rwritten_q;
	logic          out_valid_q;
	out_item_t     out_q;

	// Memory ports.
	logic          wm_we, wm_wdata, wm_rdata;
	logic [AW-1:0] wm_waddr, wm_raddr;
	logic [7:0]    img_rdata, buf_rdata;
	logic          buf_we;

	// Parser next-state values.
	logic [2:0]  ph_n;
	logic [3:0]  hi_n;
	logic [8:0]  idx_n;
	logic [7:0]  len_n, kind_n, sum_n, byte_v, byte_sum;
	logic [15:0] off_n, seen_n;
	logic [31:0] base_n, base_val;
	logic [2:0]  st_n;
	logic        b0_we, b1_we, need_commit, start_rec, idx_end;
	logic [4:0]  hx;
	logic [8:0]  boff;

	// Record address arithmetic.
	logic [32:0] start33;
	logic [33:0] end34;
	logic        range_bad, rd_in_range;

	assign hx       = hex_dec(req_q.char_code);
	assign byte_v   = {hi_q, hx[3:0]};
	assign byte_sum = sum_q + byte_v;
	assign idx_end  = (idx_q >= 9'd4 + {1'b0, len_q});
	assign boff     = idx_q - 9'd4;
	assign base_val = {16'h0000, b0_q, b1_q};

	// One character step of the record parser.
	always_comb begin
		ph_n = phase_q; hi_n = hi_q; idx_n = idx_q; len_n = len_q;
		off_n = offset_q; kind_n = kind_q; sum_n = sum_q; base_n = base_q;
		st_n = status_q; seen_n = seen_q;
		buf_we = 1'b0; b0_we = 1'b0; b1_we = 1'b0;
		need_commit = 1'b0; start_rec = 1'b0;
		unique case (phase_q)
			PH_LINE: begin
				if (req_q.char_code == CH_COLON) begin
					start_rec = 1'b1;
				end else if (req_q.char_code != CH_CR && req_q.char_code != CH_LF) begin
					st_n = ST_BADSTART; ph_n = PH_ERR;
				end
			end
			PH_TAIL: begin
				if (req_q.char_code == CH_COLON) begin
					start_rec = 1'b1;
				end else if (req_q.char_code == CH_LF) begin
					ph_n = PH_LINE;
				end
			end
			PH_HI: begin
				if (!hx[4]) begin
					st_n = ST_BADHEX; ph_n = PH_ERR;
				end else begin
					hi_n = hx[3:0]; ph_n = PH_LO;
				end
			end
			PH_LO: begin
				if (!hx[4]) begin
					st_n = ST_BADHEX; ph_n = PH_ERR;
				end else begin
					sum_n = byte_sum;
					if (idx_q == 9'd0) len_n = byte_v;
					else if (idx_q == 9'd1) off_n = {byte_v, 8'h00};
					else if (idx_q == 9'd2) off_n = {offset_q[15:8], byte_v};
					else if (idx_q == 9'd3) kind_n = byte_v;
					else if (!idx_end) buf_we = 1'b1;
					b0_we = (idx_q == 9'd4);
					b1_we = (idx_q == 9'd5);
					if (idx_end) begin
						// Record complete: checksum first, then the kind.
						if (byte_sum != 8'h00) begin
							st_n = ST_CHECKSUM; ph_n = PH_ERR;
						end else begin
							ph_n = PH_TAIL;
							unique case (kind_q)
								KIND_DATA: need_commit = 1'b1;
								KIND_EOF: begin
									st_n = ST_END; ph_n = PH_DONE;
								end
								KIND_SEG, KIND_LIN: begin
									if (len_q < 8'd2) begin
										st_n = ST_SHORT; ph_n = PH_ERR;
									end else if (kind_q == KIND_SEG) begin
										base_n = base_val << SEG_SHIFT;
									end else begin
										base_n = base_val << LIN_SHIFT;
									end
								end
								default: ;
							endcase
						end
					end else begin
						idx_n = idx_q + 9'd1; ph_n = PH_HI;
					end
				end
			end
			default: ;
		endcase
		if (start_rec) begin
			seen_n = (seen_q != 16'hFFFF) ? seen_q + 16'd1 : seen_q;
			sum_n = 8'h00; idx_n = 9'd0; hi_n = 4'h0; ph_n = PH_HI;
		end
	end

	assign start33     = {1'b0, base_q} + 33'(offset_q);
	assign end34       = {1'b0, start33} + 34'(len_q);
	assign range_bad   = end34 > 34'(MEM_DEPTH);
	assign rd_in_range = CW'(req_q.read_address) < CW'(MEM_DEPTH);

	// Status to the controller.
	assign sts.clr_done    = clr_done_q;
	assign sts.is_read     = req_q.req_type;
	assign sts.need_commit = need_commit;
	assign sts.range_bad   = range_bad;
	assign sts.len_zero    = (len_q == 8'd0);
	assign sts.strict      = strict_q;
	assign sts.overlap_hit = wm_rdata;
	assign sts.cnt_last    = (cnt_q == len_q - 8'd1);
	assign sts.out_free    = !out_valid_q || !out_stall;

	// Memory address and write selection.
	assign wm_we    = cmd.clr || cmd.wr_do;
	assign wm_waddr = cmd.clr ? clr_cnt_q : pos_q;
	assign wm_wdata = cmd.wr_do;
	assign wm_raddr = cmd.rd_issue ? AW'(req_q.read_address) : pos_q;

	ihl_ram #(.WIDTH(1), .DEPTH(MEM_DEPTH)) u_wmap (
		.clk(clk), .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
		.raddr(wm_raddr), .rdata(wm_rdata)
	);

	ihl_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_image (
		.clk(clk), .we(cmd.wr_do), .waddr(pos_q), .wdata(buf_rdata),
		.raddr(AW'(req_q.read_address)), .rdata(img_rdata)
	);

	ihl_ram #(.WIDTH(8), .DEPTH(256)) u_recbuf (
		.clk(clk), .we(cmd.exec && buf_we), .waddr(boff[7:0]),
		.wdata(byte_v), .raddr(cnt_q), .rdata(buf_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			fill_q   <= 8'h00;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_STRICT) strict_q <= cfg_data[0];
			else if (cfg_index == CFG_FILL) fill_q <= cfg_data;
		end
	end

	// Clearing pass over the written map after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(MEM_DEPTH - 1)) clr_done_q <= 1'b1;
		end
	end

	// Parser, load state and commit bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE; hi_q <= '0; idx_q <= '0; len_q <= '0;
			offset_q <= '0; kind_q <= '0; sum_q <= '0; base_q <= '0;
			top_q <= '0; low_q <= '0; any_q <= 1'b0; dist_q <= '0;
			seen_q <= '0; status_q <= ST_OK;
		end else begin
			if (cmd.exec) begin
				phase_q <= ph_n; hi_q <= hi_n; idx_q <= idx_n; len_q <= len_n;
				offset_q <= off_n; kind_q <= kind_n; sum_q <= sum_n;
				base_q <= base_n; status_q <= st_n; seen_q <= seen_n;
			end
			if (cmd.cm_init) begin
				if (range_bad) begin
					status_q <= ST_RANGE; phase_q <= PH_ERR;
				end else if (len_q == 8'd0 && end34[AW:0] > top_q) begin
					top_q <= end34[AW:0];
				end
			end
			if (cmd.chk_eval && wm_rdata) begin
				status_q <= ST_OVERLAP; phase_q <= PH_ERR;
			end
			if (cmd.wr_do) begin
				if (!wm_rdata) begin
					dist_q <= dist_q + 1'b1;
					any_q  <= 1'b1;
					if (!any_q || pos_q < low_q) low_q <= pos_q;
				end
				if (sts.cnt_last && end_q > top_q) top_q <= end_q;
			end
		end
	end

	// Request, record base bytes, commit walk and read capture registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= in_data;
		if (cmd.exec) begin
			if (b0_we) b0_q <= byte_v;
			if (b1_we) b1_q <= byte_v;
		end
		if (cmd.cm_init) begin
			start_q <= start33[AW-1:0];
			pos_q   <= start33[AW-1:0];
			end_q   <= end34[AW:0];
			cnt_q   <= 8'd0;
		end else if (cmd.chk_eval && sts.cnt_last) begin
			pos_q <= start_q;
			cnt_q <= 8'd0;
		end else if (cmd.chk_eval || cmd.wr_do) begin
			pos_q <= pos_q + 1'b1;
			cnt_q <= cnt_q + 8'd1;
		end
		if (cmd.rd_cap) begin
			rwritten_q <= rd_in_range && wm_rdata;
			rdata_q    <= (rd_in_range && wm_rdata) ? img_rdata : fill_q;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			out_q.status        <= status_q;
			out_q.read_data     <= req_q.req_type ? rdata_q : 8'h00;
			out_q.read_written  <= req_q.req_type && rwritten_q;
			out_q.image_size    <= 17'(top_q);
			out_q.useful_count  <= 17'(dist_q);
			out_q.first_address <= 16'(low_q);
			out_q.line_count    <= seen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== rtl/core/ihl_ctrl.sv =====
// Controller of the Intel HEX loader: sequences clearing, parsing, reads,
// record commits and the result hand-off.
// Depends on ihl_pkg.
module ihl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output ihl_pkg::cmd_t cmd,
	input  ihl_pkg::sts_t sts
);
	import ihl_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_EXEC  = 4'd2;
	localparam logic [3:0] S_RDW   = 4'd3;
	localparam logic [3:0] S_CMI   = 4'd4;
	localparam logic [3:0] S_CHKR  = 4'd5;
	localparam logic [3:0] S_CHKE  = 4'd6;
	localparam logic [3:0] S_WRR   = 4'd7;
	localparam logic [3:0] S_WRD   = 4'd8;
	localparam logic [3:0] S_RESP  = 4'd9;

	logic [3:0] state_q, state_n;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_n = S_IDLE;
				else cmd.clr = 1'b1;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1; state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_read) begin
					cmd.rd_issue = 1'b1; state_n = S_RDW;
				end else begin
					cmd.exec = 1'b1;
					state_n = sts.need_commit ? S_CMI : S_RESP;
				end
			end
			S_RDW: begin
				cmd.rd_cap = 1'b1; state_n = S_RESP;
			end
			S_CMI: begin
				cmd.cm_init = 1'b1;
				if (sts.range_bad || sts.len_zero) state_n = S_RESP;
				else state_n = sts.strict ? S_CHKR : S_WRR;
			end
			S_CHKR: begin
				cmd.chk_rd = 1'b1; state_n = S_CHKE;
			end
			S_CHKE: begin
				cmd.chk_eval = 1'b1;
				if (sts.overlap_hit) state_n = S_RESP;
				else state_n = sts.cnt_last ? S_WRR : S_CHKR;
			end
			S_WRR: begin
				cmd.wr_rd = 1'b1; state_n = S_WRD;
			end
			S_WRD: begin
				cmd.wr_do = 1'b1;
				state_n = sts.cnt_last ? S_RESP : S_WRR;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp = 1'b1; state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

// ===== rtl/core/intel_hex_loader_unit.sv =====
// Intel HEX loader top level. A character takes the execute and response
// steps, a read request the issue, capture and response steps; a data record's
// final character adds a commit set-up step, then a written-map read and write
// step per data byte (check steps first in strict mode). A request is taken
// only after the previous result is loaded. Reset clears all load state; all
// MEM_DEPTH written-map entries are then swept while requests stall.
module intel_hex_loader_unit #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ihl_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ihl_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import ihl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	ihl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .sts(sts)
	);

	ihl_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_stall(out_stall), .out_valid(out_valid),
		.out_data(out_data)
	);

	// An accepted request stalls the input in the cycle after acceptance.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted back to back");

	// No request is taken while the written map is being cleared.
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.clr_done |-> in_stall)
		else $error("request taken during clearing pass");

	// A new result appears only from the response step.
	a_resp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.resp))
		else $error("result raised outside response step");

	// A result is loaded only into a free output register.
	a_resp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp |-> (!out_valid || !out_stall))
		else $error("result register overwritten");
endmodule
